// ===== sv/kdsm_pkg.sv =====
// shared constants, codes and the queued operation type for the key to dense slot map
// no dependencies
`default_nettype none

package kdsm_pkg;

   localparam int KEY_SLOTS   = 256;
   localparam int STORE_DEPTH = 256;
   localparam int ITEM_BITS   = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam int KEY_AW   = $clog2(KEY_SLOTS);
   localparam int STORE_AW = $clog2(STORE_DEPTH);
   localparam int CNT_W    = $clog2(STORE_DEPTH + 1);
   localparam int QP_W     = $clog2(QUEUE_DEPTH);
   localparam int QC_W     = $clog2(QUEUE_DEPTH + 1);

   // wide enough to compare any 8 bit field against the table sizes
   localparam int CMP_W = 17;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_GET    = 2'd1;
   localparam logic [1:0] KIND_READ   = 2'd2;
   localparam logic [1:0] KIND_CLEAR  = 2'd3;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_KEY_HIGH   = 3'd1;
   localparam logic [2:0] ST_KEY_USED   = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_POS_BEYOND = 3'd4;

   localparam logic [7:0] LARGEST_KEY_RESET = 8'd255;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  key;
      logic [7:0]  position;
      logic [63:0] item_value;
      logic        key_ok;
      logic        pos_ok;
   } kdsm_op_type;

endpackage

`default_nettype wire

// ===== sv/kdsm_front.sv =====
// front end: accepts request beats, checks key and position ranges, queues operations
// depends on kdsm_pkg
`default_nettype none

module kdsm_front
   import kdsm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_key,
   input  wire logic [7:0]  req_position,
   input  wire logic [63:0] req_item_value,
   output logic             q_valid,
   output kdsm_op_type      q_op,
   input  wire logic        q_pop
);

   logic [7:0]      largest_key_ff;
   kdsm_op_type     entry_ff [QUEUE_DEPTH];
   logic [QP_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0] fill_ff, fill_in;
   kdsm_op_type     new_op;
   logic            push;
   logic            pop;

   localparam logic [CMP_W-1:0] KEY_LIMIT   = CMP_W'(KEY_SLOTS);
   localparam logic [CMP_W-1:0] STORE_LIMIT = CMP_W'(STORE_DEPTH);
   localparam logic [QC_W-1:0]  Q_FULL      = QC_W'(QUEUE_DEPTH);
   localparam logic [QP_W-1:0]  Q_LAST      = QP_W'(QUEUE_DEPTH - 1);

   always_comb begin
      new_op.kind       = req_kind;
      new_op.key        = req_key;
      new_op.position   = req_position;
      new_op.item_value = req_item_value;
      new_op.key_ok     = (req_key <= largest_key_ff) && (CMP_W'(req_key) < KEY_LIMIT);
      new_op.pos_ok     = CMP_W'(req_position) < STORE_LIMIT;
   end

   assign req_stall = (fill_ff == Q_FULL);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_op      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         largest_key_ff <= LARGEST_KEY_RESET;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         fill_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            largest_key_ff <= csr_write_data;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_op;
      end
   end

endmodule

`default_nettype wire

// ===== sv/kdsm_back.sv =====
// back end: key tables, dense item store, item count and the result register
// depends on kdsm_pkg
`default_nettype none

module kdsm_back
   import kdsm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire kdsm_op_type q_op,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic             rsp_found,
   output logic [63:0]      rsp_result_value,
   output logic [7:0]       rsp_slot,
   output logic [8:0]       rsp_item_count
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_DATA = 2'd2;

   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(STORE_DEPTH);

   logic [1:0]           state_ff, state_in;
   kdsm_op_type          op_ff;
   logic [KEY_SLOTS-1:0] key_valid_ff;
   logic [STORE_AW-1:0]  key_slot_ff [KEY_SLOTS];
   logic [ITEM_BITS-1:0] item_store_ff [STORE_DEPTH];
   logic [STORE_AW-1:0]  slot_rd_ff;
   logic [ITEM_BITS-1:0] item_rd_ff;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic [2:0]           res_status_ff, res_status_in;
   logic                 res_found_ff, res_found_in;
   logic [7:0]           res_slot_ff, res_slot_in;
   logic                 res_use_ff, res_use_in;

   logic                 rsp_valid_ff;
   logic [2:0]           rsp_status_ff;
   logic                 rsp_found_ff;
   logic [63:0]          rsp_value_ff;
   logic [7:0]           rsp_slot_ff;
   logic [8:0]           rsp_count_ff;

   logic [KEY_AW-1:0]    key_idx;
   logic [KEY_AW-1:0]    pop_key_idx;
   logic                 in_look;
   logic                 insert_we;
   logic                 clear_all;
   logic                 store_re;
   logic [STORE_AW-1:0]  store_ra;
   logic                 out_free;

   assign key_idx     = KEY_AW'(op_ff.key);
   assign pop_key_idx = KEY_AW'(q_op.key);
   assign in_look     = (state_ff == S_LOOK);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign q_pop       = (state_ff == S_IDLE) && q_valid;

   // decide the operation once the slot table read has come back
   always_comb begin
      res_status_in = ST_OK;
      res_found_in  = 1'b0;
      res_slot_in   = '0;
      res_use_in    = 1'b0;
      count_in      = count_ff;
      insert_we     = 1'b0;
      clear_all     = 1'b0;
      store_re      = 1'b0;
      store_ra      = '0;
      case (op_ff.kind)
         KIND_INSERT: begin
            if (!op_ff.key_ok) begin
               res_status_in = ST_KEY_HIGH;
            end else if (key_valid_ff[key_idx]) begin
               res_status_in = ST_KEY_USED;
            end else if (count_ff == COUNT_FULL) begin
               res_status_in = ST_FULL;
            end else begin
               insert_we   = 1'b1;
               res_slot_in = 8'(count_ff[STORE_AW-1:0]);
               count_in    = count_ff + 1'b1;
            end
         end
         KIND_GET: begin
            if (!op_ff.key_ok) begin
               res_status_in = ST_KEY_HIGH;
            end else if (key_valid_ff[key_idx]) begin
               res_found_in = 1'b1;
               res_slot_in  = 8'(slot_rd_ff);
               res_use_in   = 1'b1;
               store_re     = 1'b1;
               store_ra     = slot_rd_ff;
            end
         end
         KIND_READ: begin
            if (!op_ff.pos_ok || (CMP_W'(op_ff.position) >= CMP_W'(count_ff))) begin
               res_status_in = ST_POS_BEYOND;
            end else begin
               res_use_in = 1'b1;
               store_re   = 1'b1;
               store_ra   = STORE_AW'(op_ff.position);
            end
         end
         KIND_CLEAR: begin
            clear_all = 1'b1;
            count_in  = '0;
         end
         default: begin
            res_status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         key_valid_ff <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (in_look) begin
            count_ff <= count_in;
            if (clear_all) begin
               key_valid_ff <= '0;
            end else if (insert_we) begin
               key_valid_ff[key_idx] <= 1'b1;
            end
         end
         if ((state_ff == S_DATA) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers and the two table memories
   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff      <= q_op;
         slot_rd_ff <= key_slot_ff[pop_key_idx];
      end
      if (in_look && insert_we) begin
         key_slot_ff[key_idx]                      <= count_ff[STORE_AW-1:0];
         item_store_ff[count_ff[STORE_AW-1:0]]     <= ITEM_BITS'(op_ff.item_value);
      end
      if (in_look && store_re) begin
         item_rd_ff <= item_store_ff[store_ra];
      end
      if (in_look) begin
         res_status_ff <= res_status_in;
         res_found_ff  <= res_found_in;
         res_slot_ff   <= res_slot_in;
         res_use_ff    <= res_use_in;
      end
      if ((state_ff == S_DATA) && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_count_ff  <= 9'(count_ff);
         rsp_value_ff  <= res_use_ff ? 64'(item_rd_ff) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_item_count   = rsp_count_ff;

endmodule

`default_nettype wire

// ===== sv/key_to_dense_slot_map.sv =====
// a result beat passes through the front queue and the back end's pop, lookup and data states into its output register
// the back end finishes each item, through its pop, table lookup and store read, before it pops the next
// the front queue holds two items, so requests keep flowing while a result waits, until the queue fills
// reset: synchronous, active high; empties the queue, marks every key unused, zeroes the count
// and sets largest_key to 255; the slot table and item store are not cleared
`default_nettype none

module key_to_dense_slot_map
   import kdsm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_key,
   input  wire logic [7:0]  req_position,
   input  wire logic [63:0] req_item_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic             rsp_found,
   output logic [63:0]      rsp_result_value,
   output logic [7:0]       rsp_slot,
   output logic [8:0]       rsp_item_count
);

   logic        q_valid;
   kdsm_op_type q_op;
   logic        q_pop;

   kdsm_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_key          (req_key),
      .req_position     (req_position),
      .req_item_value   (req_item_value),
      .q_valid          (q_valid),
      .q_op             (q_op),
      .q_pop            (q_pop)
   );

   kdsm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_op             (q_op),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_result_value (rsp_result_value),
      .rsp_slot         (rsp_slot),
      .rsp_item_count   (rsp_item_count)
   );

endmodule

`default_nettype wire
